[hdl/ops_pkg.sv]
// ----------------------------------------------------------------------------
// ops_pkg
// Types, codes and constants shared by the poll scheduler modules.
// ----------------------------------------------------------------------------
package ops_pkg;

   typedef struct packed {
      logic [1:0]  func;
      logic [2:0]  slot_index;
      logic [1:0]  priority_req;
      logic [19:0] drive_interval;
      logic [19:0] door_interval;
      logic [19:0] charge_interval;
      logic [19:0] connect_interval;
      logic [1:0]  mode;
      logic        enable;
      logic [31:0] now_ms;
      logic [7:0]  queue_fill;
   } req_type;

   typedef struct packed {
      logic [2:0] status;
      logic [2:0] chosen_slot;
      logic [9:0] cooldown_ms;
   } rsp_type;

   localparam logic [1:0] FUNC_REGISTER = 2'd0;
   localparam logic [1:0] FUNC_SET_MODE = 2'd1;
   localparam logic [1:0] FUNC_SET_EN   = 2'd2;
   localparam logic [1:0] FUNC_TICK     = 2'd3;

   localparam logic [2:0] ST_DONE       = 3'd0;
   localparam logic [2:0] ST_QUIET      = 3'd1;
   localparam logic [2:0] ST_COOLDOWN   = 3'd2;
   localparam logic [2:0] ST_BACKPRESS  = 3'd3;
   localparam logic [2:0] ST_NONE_DUE   = 3'd4;
   localparam logic [2:0] ST_DISPATCHED = 3'd5;
   localparam logic [2:0] ST_FULL       = 3'd6;

   localparam logic [19:0] NEAR_TERM_LIMIT = 20'd10000;
   localparam logic [9:0]  COOL_ONE  = 10'd400;
   localparam logic [9:0]  COOL_TWO  = 10'd600;
   localparam logic [9:0]  COOL_MANY = 10'd1000;

   localparam int SCORE_W = 49;
   localparam int DIVIDEND_W = 48;

   // Priority bonus in Q.16: 0.2, 0.1, 0.05 and nothing.
   function automatic logic [13:0] prio_bonus(input logic [1:0] prio);
      logic [13:0] b;
      case (prio)
         2'd0:    b = 14'd13107;
         2'd1:    b = 14'd6554;
         2'd2:    b = 14'd3277;
         default: b = 14'd0;
      endcase
      return b;
   endfunction

endpackage

[hdl/ops_ram.sv]
// ----------------------------------------------------------------------------
// ops_ram
// Generic one-write, one-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ops_ram #(
   parameter int WIDTH = 20,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

[hdl/ops_div.sv]
// ----------------------------------------------------------------------------
// ops_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ops_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [ops_pkg::DIVIDEND_W-1:0]    dividend,
   input  logic [19:0]                       divisor,
   output logic                              done,
   output logic [ops_pkg::DIVIDEND_W-1:0]    quotient
);
   logic [ops_pkg::DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [19:0] rem_ff, rem_in, div_ff, div_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        run_ff, run_in, done_ff, done_in;
   logic [20:0] trial;
   logic        fits;

   always_comb begin
      trial  = {rem_ff, quo_ff[ops_pkg::DIVIDEND_W-1]};
      fits   = trial >= {1'b0, div_ff};
      quo_in = quo_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      cnt_in = cnt_ff;
      run_in = run_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in = dividend;
         rem_in = '0;
         div_in = divisor;
         cnt_in = 6'(ops_pkg::DIVIDEND_W - 1);
         run_in = 1'b1;
      end else if (run_ff) begin
         rem_in = fits ? 20'(trial - {1'b0, div_ff}) : trial[19:0];
         quo_in = {quo_ff[ops_pkg::DIVIDEND_W-2:0], fits};
         cnt_in = cnt_ff - 6'd1;
         if (cnt_ff == 6'd0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

[hdl/overdue_poll_scheduler_unit.sv]
// ----------------------------------------------------------------------------
// overdue_poll_scheduler_unit
// Poll slot table with a sequencer that scores overdue slots on each tick.
// ----------------------------------------------------------------------------
// Register slot writes its four intervals in turn, set mode reloads the interval
// of every slot, and a tick is paced by the shared serial divider, which runs
// once for each due slot with a nonzero interval.
// Throughput is one item at a time; busy stays high until the result strobe.
// The result is shown for one cycle on rsp_strobe; the receiver cannot stall.
// Reset is synchronous and active high; it clears all slot state but priorities.
module overdue_poll_scheduler_unit #(
   parameter int MAX_SLOTS = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  ops_pkg::req_type req_item,
   output logic             rsp_strobe,
   output ops_pkg::rsp_type rsp_item,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [2:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   // Slot index width and a counter width that can also hold MAX_SLOTS.
   localparam int SW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
   localparam int CW = $clog2(MAX_SLOTS + 1);
   localparam int MW = SW + 2;

   localparam logic [3:0] S_IDLE    = 4'd0;
   localparam logic [3:0] S_REG_WR  = 4'd1;
   localparam logic [3:0] S_MODE_RD = 4'd2;
   localparam logic [3:0] S_MODE_WR = 4'd3;
   localparam logic [3:0] S_COOL    = 4'd4;
   localparam logic [3:0] S_CHECK   = 4'd5;
   localparam logic [3:0] S_SCAN    = 4'd6;
   localparam logic [3:0] S_DIV     = 4'd7;
   localparam logic [3:0] S_FINISH  = 4'd8;

   // Configuration registers.
   logic       quiet_ff, quiet_in;
   logic [7:0] limit_ff, limit_in;

   // Slot table.
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [1:0]    prio_ff [MAX_SLOTS];
   logic [1:0]    prio_in [MAX_SLOTS];
   logic [19:0]   eff_ff  [MAX_SLOTS];
   logic [19:0]   eff_in  [MAX_SLOTS];
   logic [31:0]   lp_ff   [MAX_SLOTS];
   logic [31:0]   lp_in   [MAX_SLOTS];
   logic [MAX_SLOTS-1:0] en_ff, en_in;
   logic [1:0]    mode_ff, mode_in;
   logic          mvalid_ff, mvalid_in;
   logic [31:0]   ld_ff, ld_in;

   // Sequencer.
   logic [3:0]          state_ff, state_in;
   ops_pkg::req_type    req_ff, req_in;
   logic [CW-1:0]       i_ff, i_in;
   logic [1:0]          k_ff, k_in;
   logic [1:0]          near_ff, near_in;
   logic [9:0]          cool_ff, cool_in;
   logic                found_ff, found_in;
   logic [SW-1:0]       best_ff, best_in;
   logic [ops_pkg::SCORE_W-1:0] score_ff, score_in;

   // Result.
   logic             strobe_ff, strobe_in;
   ops_pkg::rsp_type rsp_ff, rsp_in;

   // Interval memory and shared divider.
   logic          ram_we;
   logic [MW-1:0] ram_waddr, ram_raddr;
   logic [19:0]   ram_wdata, ram_rdata;
   logic          div_start, div_done;
   logic [ops_pkg::DIVIDEND_W-1:0] div_quo;

   logic [SW-1:0] ix;
   logic [31:0]   elapsed;
   logic [ops_pkg::SCORE_W-1:0] cand;
   logic          csr_wr;

   assign ix      = i_ff[SW-1:0];
   assign elapsed = req_ff.now_ms - lp_ff[ix];
   assign cand    = ops_pkg::SCORE_W'(div_quo) +
                    ops_pkg::SCORE_W'(ops_pkg::prio_bonus(prio_ff[ix]));
   assign csr_wr  = psel & penable & pwrite;

   ops_ram #(.WIDTH(20), .DEPTH(2 ** MW)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   ops_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend ({elapsed, 16'd0}),
      .divisor  (eff_ff[ix]),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_comb begin
      quiet_in  = quiet_ff;
      limit_in  = limit_ff;
      cnt_in    = cnt_ff;
      prio_in   = prio_ff;
      eff_in    = eff_ff;
      lp_in     = lp_ff;
      en_in     = en_ff;
      mode_in   = mode_ff;
      mvalid_in = mvalid_ff;
      ld_in     = ld_ff;
      state_in  = state_ff;
      req_in    = req_ff;
      i_in      = i_ff;
      k_in      = k_ff;
      near_in   = near_ff;
      cool_in   = cool_ff;
      found_in  = found_ff;
      best_in   = best_ff;
      score_in  = score_ff;
      strobe_in = 1'b0;
      rsp_in    = rsp_ff;
      ram_we    = 1'b0;
      ram_waddr = {cnt_ff[SW-1:0], k_ff};
      ram_wdata = req_ff.connect_interval;
      ram_raddr = {ix, req_ff.mode};
      div_start = 1'b0;

      // Register writes take effect at once; the user must issue them only while idle; not enforced here.
      if (csr_wr) begin
         if (paddr[2]) begin
            limit_in = pwdata[7:0];
         end else begin
            quiet_in = pwdata[0];
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               req_in   = req_item;
               i_in     = '0;
               k_in     = '0;
               near_in  = '0;
               found_in = 1'b0;
               best_in  = '0;
               score_in = '0;
               rsp_in   = '{status: ops_pkg::ST_DONE, chosen_slot: 3'd0,
                            cooldown_ms: 10'd0};
               state_in = S_FINISH;
               case (req_item.func)
                  ops_pkg::FUNC_REGISTER: begin
                     if (cnt_ff == CW'(MAX_SLOTS)) begin
                        rsp_in.status = ops_pkg::ST_FULL;
                     end else begin
                        prio_in[cnt_ff[SW-1:0]] = req_item.priority_req;
                        eff_in[cnt_ff[SW-1:0]]  = '0;
                        en_in[cnt_ff[SW-1:0]]   = 1'b0;
                        lp_in[cnt_ff[SW-1:0]]   = '0;
                        state_in = S_REG_WR;
                     end
                  end
                  ops_pkg::FUNC_SET_MODE: begin
                     if (!(req_item.mode == mode_ff && mvalid_ff)) begin
                        mode_in   = req_item.mode;
                        mvalid_in = 1'b1;
                        state_in  = S_MODE_RD;
                     end
                  end
                  ops_pkg::FUNC_SET_EN: begin
                     if (6'(req_item.slot_index) < 6'(cnt_ff)) begin
                        en_in[SW'(req_item.slot_index)] = req_item.enable;
                     end
                  end
                  default: begin
                     state_in = S_COOL;
                  end
               endcase
            end
         end
         S_REG_WR: begin
            // One interval per cycle, stored at slot*4 + mode.
            ram_we = 1'b1;
            case (k_ff)
               2'd0:    ram_wdata = req_ff.connect_interval;
               2'd1:    ram_wdata = req_ff.drive_interval;
               2'd2:    ram_wdata = req_ff.door_interval;
               default: ram_wdata = req_ff.charge_interval;
            endcase
            k_in = k_ff + 2'd1;
            if (k_ff == 2'd3) begin
               cnt_in   = cnt_ff + CW'(1);
               state_in = S_FINISH;
            end
         end
         S_MODE_RD: begin
            state_in = (i_ff == cnt_ff) ? S_FINISH : S_MODE_WR;
         end
         S_MODE_WR: begin
            eff_in[ix] = ram_rdata;
            en_in[ix]  = ram_rdata != 20'd0;
            i_in       = i_ff + CW'(1);
            state_in   = S_MODE_RD;
         end
         S_COOL: begin
            if (i_ff == cnt_ff) begin
               case (near_ff)
                  2'd0, 2'd1: cool_in = ops_pkg::COOL_ONE;
                  2'd2:       cool_in = ops_pkg::COOL_TWO;
                  default:    cool_in = ops_pkg::COOL_MANY;
               endcase
               i_in     = '0;
               state_in = S_CHECK;
            end else begin
               if (en_ff[ix] && eff_ff[ix] != 20'd0 &&
                   eff_ff[ix] <= ops_pkg::NEAR_TERM_LIMIT && near_ff != 2'd3) begin
                  near_in = near_ff + 2'd1;
               end
               i_in = i_ff + CW'(1);
            end
         end
         S_CHECK: begin
            rsp_in.cooldown_ms = cool_ff;
            if (quiet_ff) begin
               rsp_in.status = ops_pkg::ST_QUIET;
               state_in = S_FINISH;
            end else if (ld_ff != 32'd0 &&
                         (req_ff.now_ms - ld_ff) < {22'd0, cool_ff}) begin
               rsp_in.status = ops_pkg::ST_COOLDOWN;
               state_in = S_FINISH;
            end else if (req_ff.queue_fill >= limit_ff) begin
               rsp_in.status = ops_pkg::ST_BACKPRESS;
               state_in = S_FINISH;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (i_ff == cnt_ff || (en_ff[ix] && lp_ff[ix] == 32'd0)) begin
               // End of the table, or an enabled never-polled slot ends the search.
               if (i_ff != cnt_ff || found_ff) begin
                  if (i_ff != cnt_ff) begin
                     lp_in[ix]          = req_ff.now_ms;
                     rsp_in.chosen_slot = 3'(ix);
                  end else begin
                     lp_in[best_ff]     = req_ff.now_ms;
                     rsp_in.chosen_slot = 3'(best_ff);
                  end
                  ld_in         = req_ff.now_ms;
                  rsp_in.status = ops_pkg::ST_DISPATCHED;
               end else begin
                  rsp_in.status = ops_pkg::ST_NONE_DUE;
               end
               state_in = S_FINISH;
            end else if (!en_ff[ix] || elapsed < {12'd0, eff_ff[ix]}) begin
               i_in = i_ff + CW'(1);
            end else if (eff_ff[ix] == 20'd0) begin
               // A zero interval scores the maximum.
               if (score_ff != '1) begin
                  score_in = '1;
                  best_in  = ix;
                  found_in = 1'b1;
               end
               i_in = i_ff + CW'(1);
            end else begin
               div_start = 1'b1;
               state_in  = S_DIV;
            end
         end
         S_DIV: begin
            if (div_done) begin
               if (cand > score_ff) begin
                  score_in = cand;
                  best_in  = ix;
                  found_in = 1'b1;
               end
               i_in     = i_ff + CW'(1);
               state_in = S_SCAN;
            end
         end
         S_FINISH: begin
            strobe_in = 1'b1;
            state_in  = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quiet_ff  <= 1'b0;
         limit_ff  <= 8'd8;
         cnt_ff    <= '0;
         for (int n = 0; n < MAX_SLOTS; n++) begin
            eff_ff[n] <= '0;
            lp_ff[n]  <= '0;
         end
         en_ff     <= '0;
         mode_ff   <= '0;
         mvalid_ff <= 1'b0;
         ld_ff     <= '0;
         state_ff  <= S_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         quiet_ff  <= quiet_in;
         limit_ff  <= limit_in;
         cnt_ff    <= cnt_in;
         eff_ff    <= eff_in;
         lp_ff     <= lp_in;
         en_ff     <= en_in;
         mode_ff   <= mode_in;
         mvalid_ff <= mvalid_in;
         ld_ff     <= ld_in;
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
      prio_ff  <= prio_in;
      req_ff   <= req_in;
      i_ff     <= i_in;
      k_ff     <= k_in;
      near_ff  <= near_in;
      cool_ff  <= cool_in;
      found_ff <= found_in;
      best_ff  <= best_in;
      score_ff <= score_in;
      rsp_ff   <= rsp_in;
   end

   assign busy       = state_ff != S_IDLE;
   assign rsp_strobe = strobe_ff;
   assign rsp_item   = rsp_ff;
   assign pready     = 1'b1;
   assign prdata     = paddr[2] ? {24'd0, limit_ff} : {31'd0, quiet_ff};
endmodule

[hdl/ops_chk.sv]
// ----------------------------------------------------------------------------
// ops_chk
// Port-level checks on the poll scheduler, bound to the top level.
// ----------------------------------------------------------------------------
module ops_chk (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_strobe,
   input ops_pkg::rsp_type rsp_item
);
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("accepted item did not raise busy");

   a_fell_strobe: assert property (@(posedge clock) disable iff (reset)
      $fell(busy) |-> rsp_strobe) else $error("busy dropped without a result");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy) else $error("result strobe while busy");

   a_chosen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.status != ops_pkg::ST_DISPATCHED
      |-> rsp_item.chosen_slot == 3'd0) else $error("slot reported without dispatch");

   a_tick_cool: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_item.status != ops_pkg::ST_DONE &&
      rsp_item.status != ops_pkg::ST_FULL
      |-> rsp_item.cooldown_ms == ops_pkg::COOL_ONE ||
          rsp_item.cooldown_ms == ops_pkg::COOL_TWO ||
          rsp_item.cooldown_ms == ops_pkg::COOL_MANY)
      else $error("tick result without a valid cooldown");
endmodule

bind overdue_poll_scheduler_unit ops_chk u_ops_chk (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_item   (rsp_item)
);
